// ===== src/renocw_pkg.sv =====
// package for the reno congestion window unit
// holds phase codes, register indexes, state and result types and the reload function
// no dependencies
`default_nettype none

package renocw_pkg;

  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CNT_W-1:0] DUP_LIMIT = CNT_W'(3);

  // event codes
  localparam logic OP_ACK  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_SEQ        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd4;

  typedef enum logic [1:0] {
    PH_SLOW  = 2'd0,
    PH_AVOID = 2'd1,
    PH_RECOV = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] init_window;
    logic [CNT_W-1:0] init_threshold;
    logic [SEQ_W-1:0] start_seq;
    logic [SEQ_W-1:0] end_seq;
    logic [CNT_W-1:0] timeout_ticks;
  } cw_cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] window;
    logic [CNT_W-1:0] threshold;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] last_ack;
    logic [CNT_W-1:0] dup_count;
    logic [CNT_W-1:0] idle_ticks;
  } cw_state_t;

  typedef struct packed {
    logic [SEQ_W-1:0] window_base;
    logic [CNT_W-1:0] window_size;
    phase_t           phase;
    logic             retransmit;
    logic             done_res;
  } cw_result_t;

  localparam cw_cfg_t CFG_RESET = '{
    init_window:    16'd1,
    init_threshold: 16'd32,
    start_seq:      32'd0,
    end_seq:        32'd0,
    timeout_ticks:  16'd2000
  };

  // state at the start of a transfer
  function automatic cw_state_t load_state(input cw_cfg_t cfg);
    cw_state_t s;
    s.phase      = PH_SLOW;
    s.window     = cfg.init_window;
    s.threshold  = cfg.init_threshold;
    s.base       = cfg.start_seq;
    s.last_ack   = '0;
    s.dup_count  = '0;
    s.idle_ticks = '0;
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/renocw_if.sv =====
// valid/ready channel interfaces for the reno congestion window unit
// event word in, window result word out; uses renocw_pkg
`default_nettype none

interface renocw_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [renocw_pkg::SEQ_W-1:0]   ack_number;

  modport source (output valid, output opcode, output ack_number, input ready);
  modport sink   (input valid, input opcode, input ack_number, output ready);
endinterface

interface renocw_out_if;
  logic                           valid;
  logic                           ready;
  logic [renocw_pkg::SEQ_W-1:0]   window_base;
  logic [renocw_pkg::CNT_W-1:0]   window_size;
  logic [1:0]                     phase;
  logic                           retransmit;
  logic                           done_res;

  modport source (output valid, output window_base, output window_size, output phase,
                  output retransmit, output done_res, input ready);
  modport sink   (input valid, input window_base, input window_size, input phase,
                  input retransmit, input done_res, output ready);
endinterface

`default_nettype wire

// ===== src/renocw_cfg.sv =====
// configuration registers of the reno congestion window unit
// decodes the write port and flags a transfer restart; uses renocw_pkg
`default_nettype none

module renocw_cfg (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire [renocw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [renocw_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  output renocw_pkg::cw_cfg_t                 cfg_o,
  output renocw_pkg::cw_cfg_t                 cfg_nxt_o,
  output logic                                reload_o
);
  import renocw_pkg::*;

  cw_cfg_t cfg_r;
  cw_cfg_t cfg_nxt;
  logic    hit;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    unique case (cfg_index)
      CFG_INIT_WINDOW: begin
        cfg_nxt.init_window = cfg_wdata[CNT_W-1:0];
        hit = 1'b1;
      end
      CFG_INIT_THRESHOLD: begin
        cfg_nxt.init_threshold = cfg_wdata[CNT_W-1:0];
        hit = 1'b1;
      end
      CFG_START_SEQ: begin
        cfg_nxt.start_seq = cfg_wdata[SEQ_W-1:0];
        hit = 1'b1;
      end
      CFG_END_SEQ: begin
        cfg_nxt.end_seq = cfg_wdata[SEQ_W-1:0];
        hit = 1'b1;
      end
      CFG_TIMEOUT_TICKS: begin
        cfg_nxt.timeout_ticks = cfg_wdata[CNT_W-1:0];
        hit = 1'b1;
      end
      default: hit = 1'b0;
    endcase
  end

  assign reload_o  = cfg_we && hit;
  assign cfg_o     = cfg_r;
  assign cfg_nxt_o = cfg_nxt;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (reload_o) begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/renocw_next.sv =====
// next-state logic of the reno congestion window unit
// one event word against the current state; uses renocw_pkg
`default_nettype none

module renocw_next (
  input  renocw_pkg::cw_state_t            state_i,
  input  renocw_pkg::cw_cfg_t              cfg_i,
  input  wire                              opcode_i,
  input  wire [renocw_pkg::SEQ_W-1:0]      ack_i,
  output renocw_pkg::cw_state_t            state_o,
  output renocw_pkg::cw_result_t           result_o
);
  import renocw_pkg::*;

  always_comb begin
    cw_state_t        s;
    logic             rtx;
    logic             done;
    logic [SEQ_W-1:0] diff;
    logic [SEQ_W:0]   sum_ss;
    logic [CNT_W:0]   sum_one;
    logic [CNT_W:0]   sum_dup;

    s       = state_i;
    rtx     = 1'b0;
    done    = 1'b0;
    diff    = '0;
    sum_ss  = '0;
    sum_one = '0;
    sum_dup = '0;

    if (opcode_i == OP_TICK) begin
      // idle tick counter and timeout
      if (s.idle_ticks != CNT_MAX) begin
        s.idle_ticks = s.idle_ticks + CNT_W'(1);
      end
      if (s.idle_ticks > cfg_i.timeout_ticks) begin
        rtx          = 1'b1;
        s.idle_ticks = '0;
      end
    end else begin
      // duplicate ack and fast retransmit
      if (ack_i == s.last_ack) begin
        if (s.dup_count != CNT_MAX) begin
          s.dup_count = s.dup_count + CNT_W'(1);
        end
        if (s.dup_count >= DUP_LIMIT && s.phase != PH_RECOV) begin
          s.threshold  = s.window >> 1;
          s.window     = s.threshold + CNT_W'(3);
          s.base       = s.last_ack;
          s.phase      = PH_RECOV;
          s.idle_ticks = '0;
          rtx          = 1'b1;
        end
      end
      // new ack, against the base as left above
      if (ack_i > s.base) begin
        s.last_ack = ack_i;
        if (ack_i >= cfg_i.end_seq) begin
          s.dup_count = '0;
          done        = 1'b1;
        end else begin
          diff    = ack_i - s.base;
          sum_ss  = {{(SEQ_W-CNT_W+1){1'b0}}, s.window} + {1'b0, diff};
          sum_one = {1'b0, s.window} + {{CNT_W{1'b0}}, 1'b1};
          sum_dup = {1'b0, s.window} + {1'b0, s.dup_count};
          case (s.phase)
            PH_SLOW: begin
              s.window = (sum_ss[SEQ_W:CNT_W] != '0) ? CNT_MAX : sum_ss[CNT_W-1:0];
              if (s.window >= s.threshold) begin
                s.phase = PH_AVOID;
              end
            end
            PH_AVOID: begin
              s.window = sum_one[CNT_W] ? CNT_MAX : sum_one[CNT_W-1:0];
            end
            default: begin
              s.window = sum_dup[CNT_W] ? CNT_MAX : sum_dup[CNT_W-1:0];
              s.phase  = PH_AVOID;
            end
          endcase
          s.dup_count  = '0;
          s.base       = ack_i;
          s.idle_ticks = '0;
        end
      end
    end

    state_o              = s;
    result_o.window_base = s.base;
    result_o.window_size = s.window;
    result_o.phase       = s.phase;
    result_o.retransmit  = rtx;
    result_o.done_res    = done;
  end

endmodule

`default_nettype wire

// ===== src/reno_congestion_window_unit.sv =====
// top level of the reno congestion window unit
// input register, state update, result register; uses renocw_pkg, renocw_if,
// renocw_cfg and renocw_next
//
// usage
//   in_ch carries one event word: opcode (ack received or timer tick) and the
//   cumulative ack number. out_ch returns one result word per event: window
//   base, window size, phase, retransmit request and end-of-transfer flag,
//   all as left after the event.
//   the cfg port writes one register per cycle when cfg_we is high; any write
//   to a listed register restarts the transfer from the register values.
//   the input register takes the word at the accepting edge; the state update
//   lands in the result register once the result slot is free, and out_ch.valid
//   rises with it. throughput is one event per cycle while out_ch does not
//   stall; the window state feeds back through combinational compare and add
//   logic.
//   when out_ch stalls, the result register holds its word and the input
//   register takes one more event, then in_ch.ready drops until out_ch moves.
//   reset (synchronous, rst_n low) empties both registers and loads the
//   default register values and the start-of-transfer state.
`default_nettype none

module reno_congestion_window_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  renocw_in_if.sink                           in_ch,
  renocw_out_if.source                        out_ch,
  input  wire                                 cfg_we,
  input  wire [renocw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [renocw_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import renocw_pkg::*;

  cw_cfg_t    cfg;
  cw_cfg_t    cfg_nxt;
  logic       cfg_load;

  logic             in_valid_r;
  logic             opcode_r;
  logic [SEQ_W-1:0] ack_r;

  cw_state_t  state_r;
  cw_state_t  state_nxt;
  cw_result_t result_nxt;
  cw_result_t result_r;
  logic       out_valid_r;
  logic       advance;

  renocw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg),
    .cfg_nxt_o (cfg_nxt),
    .reload_o  (cfg_load)
  );

  renocw_next u_next (
    .state_i  (state_r),
    .cfg_i    (cfg),
    .opcode_i (opcode_r),
    .ack_i    (ack_r),
    .state_o  (state_nxt),
    .result_o (result_nxt)
  );

  // handshake: the word in the input register moves when the result slot frees
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      opcode_r <= in_ch.opcode;
      ack_r    <= in_ch.ack_number;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= load_state(CFG_RESET);
    end else if (cfg_load) begin
      state_r <= load_state(cfg_nxt);
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.window_base = result_r.window_base;
  assign out_ch.window_size = result_r.window_size;
  assign out_ch.phase       = result_r.phase;
  assign out_ch.retransmit  = result_r.retransmit;
  assign out_ch.done_res    = result_r.done_res;

  // a retransmit request always restarts the idle timer
  a_rtx_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !cfg_load && result_nxt.retransmit) |=> (state_r.idle_ticks == '0))
    else $error("idle ticks not cleared after retransmit");

  // reaching the end sequence leaves the window base where it was
  a_done_keeps_base: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !cfg_load && result_nxt.done_res) |=> (state_r.base == $past(state_r.base)))
    else $error("window base moved on end of transfer");

  // every processed event lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed event lost");

  // a waiting event word is held until it moves on
  a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(ack_r) && $stable(opcode_r)))
    else $error("stalled event word changed");

endmodule

`default_nettype wire

// ===== test/reno_congestion_window_unit_tb.sv =====
// testbench for reno_congestion_window_unit: event words in, window result words out,
// each result checked against a cycle-free model of the window state kept here
// depends on renocw_pkg, renocw_if and the unit itself
`default_nettype none

module reno_congestion_window_unit_tb;
  import renocw_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RUN_ITEMS   = 38;

  typedef struct packed {
    logic             opcode;
    logic [SEQ_W-1:0] ack;
  } cw_event_t;

  typedef struct packed {
    cw_state_t  st;
    cw_result_t res;
  } cw_step_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  renocw_in_if  in_ch ();
  renocw_out_if out_ch ();

  reno_congestion_window_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copy, state as planned by the stimulus, state as seen by accepted words
  cw_cfg_t    run_cfg;
  cw_state_t  plan_state;
  cw_state_t  live_state;

  cw_event_t  pending_events[$];
  cw_result_t expected_windows[$];

  int events_queued;
  int results_checked;
  int error_count;
  int stall_cycles;

  // clamp a wide count to the 16 bit range
  function automatic logic [CNT_W-1:0] clamp_count(input logic [32:0] v);
    return (v > {17'd0, CNT_MAX}) ? CNT_MAX : v[CNT_W-1:0];
  endfunction

  // one event applied to the window state, result word as left after it
  function automatic cw_step_t advance_window(input cw_state_t s, input cw_cfg_t c,
                                              input logic op, input logic [SEQ_W-1:0] ack);
    cw_step_t   nx;
    logic       rtx;
    logic       fin;
    rtx = 1'b0;
    fin = 1'b0;
    if (op == OP_TICK) begin
      s.idle_ticks = clamp_count({17'd0, s.idle_ticks} + 33'd1);
      if (s.idle_ticks > c.timeout_ticks) begin
        rtx = 1'b1;
        s.idle_ticks = '0;
      end
    end else begin
      // duplicate ack, third one triggers fast retransmit outside recovery
      if (ack == s.last_ack) begin
        s.dup_count = clamp_count({17'd0, s.dup_count} + 33'd1);
        if (s.dup_count >= DUP_LIMIT && s.phase != PH_RECOV) begin
          s.threshold  = s.window >> 1;
          s.window     = clamp_count({17'd0, s.threshold} + 33'd3);
          s.base       = s.last_ack;
          s.phase      = PH_RECOV;
          s.idle_ticks = '0;
          rtx          = 1'b1;
        end
      end
      // new ack moves the base, or ends the transfer
      if (ack > s.base) begin
        s.last_ack = ack;
        if (ack >= c.end_seq) begin
          s.dup_count = '0;
          fin = 1'b1;
        end else begin
          case (s.phase)
            PH_SLOW: begin
              s.window = clamp_count({17'd0, s.window} + {1'b0, ack - s.base});
              if (s.window >= s.threshold) s.phase = PH_AVOID;
            end
            PH_AVOID: begin
              s.window = clamp_count({17'd0, s.window} + 33'd1);
            end
            default: begin
              s.window = clamp_count({17'd0, s.window} + {17'd0, s.dup_count});
              s.phase  = PH_AVOID;
            end
          endcase
          s.dup_count  = '0;
          s.base       = ack;
          s.idle_ticks = '0;
        end
      end
    end
    nx.st                  = s;
    nx.res.window_base     = s.base;
    nx.res.window_size     = s.window;
    nx.res.phase           = s.phase;
    nx.res.retransmit      = rtx;
    nx.res.done_res        = fin;
    return nx;
  endfunction

  // start of transfer from the current register values
  function automatic void restart_transfer();
    cw_state_t s;
    s.phase      = PH_SLOW;
    s.window     = run_cfg.init_window;
    s.threshold  = run_cfg.init_threshold;
    s.base       = run_cfg.start_seq;
    s.last_ack   = '0;
    s.dup_count  = '0;
    s.idle_ticks = '0;
    plan_state   = s;
    live_state   = s;
  endfunction

  function automatic void queue_event(input logic op, input logic [SEQ_W-1:0] ack);
    cw_event_t ev;
    cw_step_t  nx;
    ev.opcode = op;
    ev.ack    = ack;
    pending_events.push_back(ev);
    nx = advance_window(plan_state, run_cfg, op, ack);
    plan_state = nx.st;
    events_queued++;
  endfunction

  // register write, only issued while the unit is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_INIT_WINDOW:    run_cfg.init_window    = data[CNT_W-1:0];
      CFG_INIT_THRESHOLD: run_cfg.init_threshold = data[CNT_W-1:0];
      CFG_START_SEQ:      run_cfg.start_seq      = data;
      CFG_END_SEQ:        run_cfg.end_seq        = data;
      CFG_TIMEOUT_TICKS:  run_cfg.timeout_ticks  = data[CNT_W-1:0];
      default: ;
    endcase
    if (idx <= CFG_TIMEOUT_TICKS) restart_transfer();
  endtask

  // wait for every result, then let the pipeline empty
  task automatic settle();
    while (results_checked != events_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // stimulus
  initial begin
    int                   target;
    int                   phase_no;
    int                   pick;
    logic [CNT_W-1:0]     win;
    logic [CNT_W-1:0]     thr;
    logic [CNT_W-1:0]     tmo;
    logic [SEQ_W-1:0]     first_seq;
    logic [SEQ_W-1:0]     last_seq;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_ACK;
    in_ch.ack_number = '0;
    out_ch.ready     = 1'b0;
    events_queued    = 0;
    results_checked  = 0;
    error_count      = 0;
    run_cfg          = CFG_RESET;
    restart_transfer();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: end sequence zero, so any new ack ends the transfer
    queue_event(OP_ACK, 32'd0);
    queue_event(OP_ACK, 32'hFFFF_FFFF);
    queue_event(OP_TICK, 32'd0);
    settle();

    // slow start into avoidance, timeout, fast retransmit, recovery, old ack, end
    write_reg(CFG_INIT_WINDOW, 32'd1);
    write_reg(CFG_INIT_THRESHOLD, 32'd2);
    write_reg(CFG_START_SEQ, 32'd100);
    write_reg(CFG_END_SEQ, 32'hFFFF_FFFF);
    write_reg(CFG_TIMEOUT_TICKS, 32'd1);
    queue_event(OP_TICK, 32'd0);
    queue_event(OP_TICK, 32'hFFFF_FFFF);
    queue_event(OP_ACK, 32'd101);
    repeat (5) queue_event(OP_ACK, 32'd102);
    queue_event(OP_ACK, 32'd105);
    queue_event(OP_ACK, 32'd50);
    queue_event(OP_ACK, 32'hFFFF_FFFF);
    settle();

    // window of one halved to a zero threshold
    write_reg(CFG_START_SEQ, 32'd0);
    repeat (3) queue_event(OP_ACK, 32'd0);
    queue_event(OP_ACK, 32'd1);
    settle();

    // window saturation in slow start and avoidance
    write_reg(CFG_INIT_WINDOW, 32'd60000);
    write_reg(CFG_INIT_THRESHOLD, 32'hABCD_FFFF);
    queue_event(OP_ACK, 32'd10000);
    repeat (4) queue_event(OP_ACK, 32'd10001);

    // random transfers under a series of register settings
    for (phase_no = 0; phase_no < 10; phase_no++) begin
      settle();
      if (phase_no % 3 == 2) begin
        // unused index, the transfer carries on
        write_reg(CFG_TIMEOUT_TICKS + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
      end else begin
        win       = CNT_W'($urandom_range(1, 64));
        thr       = CNT_W'($urandom_range(1, 128));
        tmo       = CNT_W'($urandom_range(1, 12));
        first_seq = $urandom;
        last_seq  = first_seq + $urandom_range(200, 3000);
        case (phase_no)
          0: begin
            win = CNT_W'(1); thr = CNT_MAX; first_seq = '0; last_seq = 32'd2000;
            tmo = CNT_W'(3);
          end
          1: begin
            win = CNT_MAX; thr = CNT_W'(1); tmo = CNT_W'(1);
          end
          3: begin
            first_seq = 32'hFFFF_FF00; last_seq = 32'hFFFF_FFFF; tmo = CNT_MAX;
          end
          4: begin
            win = CNT_W'(1); thr = CNT_W'(1); last_seq = first_seq;
          end
          6: begin
            win = CNT_W'($urandom_range(1, 65535));
            thr = CNT_W'($urandom_range(1, 65535));
          end
          7: begin
            first_seq = '0; last_seq = 32'd50;
          end
          default: ;
        endcase
        write_reg(CFG_INIT_WINDOW, {16'($urandom), win});
        write_reg(CFG_INIT_THRESHOLD, {16'($urandom), thr});
        write_reg(CFG_START_SEQ, first_seq);
        write_reg(CFG_END_SEQ, last_seq);
        write_reg(CFG_TIMEOUT_TICKS, {16'($urandom), tmo});
      end

      // mostly well-formed ack streams, some ticks, old acks and noise
      target = events_queued + RUN_ITEMS;
      while (events_queued < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 15)
          repeat ($urandom_range(1, 15)) queue_event(OP_TICK, $urandom);
        else if (pick < 35)
          repeat ($urandom_range(1, 5)) queue_event(OP_ACK, plan_state.last_ack);
        else if (pick < 75)
          queue_event(OP_ACK, plan_state.base + $urandom_range(1, 8));
        else if (pick < 80)
          queue_event(OP_ACK, plan_state.base + $urandom_range(1, 3000));
        else if (pick < 90)
          queue_event(OP_ACK, plan_state.base - $urandom_range(0, 20));
        else
          queue_event(OP_ACK, $urandom);
      end
    end

    settle();
    if (expected_windows.size() != 0) begin
      $error("%0d result words never arrived", expected_windows.size());
      error_count++;
    end
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // event driver: bursts of words with gaps, predicts each accepted word
  int        burst_left;
  int        gap_left;
  cw_event_t drive_ev;
  cw_step_t  drive_step;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        drive_step = advance_window(live_state, run_cfg, in_ch.opcode, in_ch.ack_number);
        live_state = drive_step.st;
        expected_windows.push_back(drive_step.res);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          drive_ev = pending_events.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.opcode     <= drive_ev.opcode;
          in_ch.ack_number <= drive_ev.ack;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: stall pattern by window of cycles, one long hold-off
  int rx_cycle;
  int hold_left;
  bit squeezed;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cycle  = 0;
      hold_left = 0;
      squeezed  = 1'b0;
    end else begin
      rx_cycle++;
      if (!squeezed && results_checked > 60 && pending_events.size() > 20) begin
        squeezed  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_cycle[7:6])
          2'd0:    out_ch.ready <= 1'b1;
          2'd1:    out_ch.ready <= ($urandom_range(0, 1) == 1);
          2'd2:    out_ch.ready <= (rx_cycle[1:0] != 2'd0);
          default: out_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // result checker
  cw_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (expected_windows.size() == 0) begin
        $error("result word with no event outstanding");
        error_count++;
      end else begin
        want = expected_windows.pop_front();
        if (out_ch.window_base !== want.window_base) begin
          $error("window_base: expected %0h, got %0h", want.window_base, out_ch.window_base);
          error_count++;
        end
        if (out_ch.window_size !== want.window_size) begin
          $error("window_size: expected %0d, got %0d", want.window_size, out_ch.window_size);
          error_count++;
        end
        if (out_ch.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, out_ch.phase);
          error_count++;
        end
        if (out_ch.retransmit !== want.retransmit) begin
          $error("retransmit: expected %0b, got %0b", want.retransmit, out_ch.retransmit);
          error_count++;
        end
        if (out_ch.done_res !== want.done_res) begin
          $error("done_res: expected %0b, got %0b", want.done_res, out_ch.done_res);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

`default_nettype wire
